@@ rtl/ebc_pkg.sv @@
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants for the eight-bit core subset.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 16;

  // bus access kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindIdle  = 2'd2;

  // sequencing steps
  localparam logic [3:0] StVec  = 4'd0;
  localparam logic [3:0] StOpc  = 4'd1;
  localparam logic [3:0] StA2   = 4'd2;
  localparam logic [3:0] StA3   = 4'd3;
  localparam logic [3:0] StA4   = 4'd4;
  localparam logic [3:0] StA5   = 4'd5;
  localparam logic [3:0] StData = 4'd10;
  localparam logic [3:0] StDone = 4'd11;
  localparam logic [3:0] StRmwR = 4'd12;
  localparam logic [3:0] StRmwW = 4'd13;
  localparam logic [3:0] StPush = 4'd14;

  // reset vector phases
  localparam logic [1:0] RpLow  = 2'd0;
  localparam logic [1:0] RpHigh = 2'd1;
  localparam logic [1:0] RpLoad = 2'd2;
  localparam logic [1:0] RpRun  = 2'd3;

  localparam logic [15:0] VecLo = 16'hFFFC;
  localparam logic [15:0] VecHi = 16'hFFFD;
  localparam logic [7:0]  SpRst = 8'hFD;
  localparam logic [7:0]  PRst  = 8'h20;

  typedef enum logic [3:0] {
    M_NONE, M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY,
    M_XIND, M_INDY, M_PUSH, M_PULL
  } mode_e;

  typedef enum logic [4:0] {
    C_NONE, C_LDA, C_LDX, C_LDY, C_STA, C_STX, C_STY, C_ADC, C_SBC,
    C_AND, C_EOR, C_ORA, C_INC, C_DEC, C_TAX, C_TAY, C_TSX, C_TXA,
    C_TXS, C_TYA, C_DEX, C_DEY, C_INX, C_INY, C_PHA, C_PHP, C_PLA, C_PLP
  } cls_e;

  typedef struct packed {
    cls_e  cls;
    mode_e mode;
  } dec_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [1:0]  access_kind;
    logic [7:0]  write_data;
    logic        opcode_fetch;
    logic [7:0]  acc_value;
    logic [7:0]  x_value;
    logic [7:0]  y_value;
    logic [7:0]  stack_value;
    logic [7:0]  flag_bits;
  } res_t;

endpackage

@@ rtl/ebc_if.sv @@
// ----------------------------------------------------------------------------
// ebc_in_if / ebc_out_if
// Valid/ready channels carrying the read byte and the bus cycle result.
// ----------------------------------------------------------------------------
interface ebc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

interface ebc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic [1:0]  access_kind;
  logic [7:0]  write_data;
  logic        opcode_fetch;
  logic [7:0]  acc_value;
  logic [7:0]  x_value;
  logic [7:0]  y_value;
  logic [7:0]  stack_value;
  logic [7:0]  flag_bits;
  modport source (output valid, output bus_address, output access_kind,
                  output write_data, output opcode_fetch, output acc_value,
                  output x_value, output y_value, output stack_value,
                  output flag_bits, input ready);
  modport sink (input valid, input bus_address, input access_kind,
                input write_data, input opcode_fetch, input acc_value,
                input x_value, input y_value, input stack_value,
                input flag_bits, output ready);
endinterface

@@ rtl/ebc_decode.sv @@
// ----------------------------------------------------------------------------
// ebc_decode
// Opcode decoder: instruction class and addressing mode.
// ----------------------------------------------------------------------------
module ebc_decode import ebc_pkg::*; (
  input  logic [7:0] opcode_i,
  output dec_t       dec_o
);

  // group one table lookups, other opcodes matched one by one
  always_comb begin
    dec_o.cls  = C_NONE;
    dec_o.mode = M_NONE;
    if (opcode_i[1:0] == 2'b01) begin
      case (opcode_i[7:5])
        3'd0: dec_o.cls = C_ORA;
        3'd1: dec_o.cls = C_AND;
        3'd2: dec_o.cls = C_EOR;
        3'd3: dec_o.cls = C_ADC;
        3'd4: dec_o.cls = C_STA;
        3'd5: dec_o.cls = C_LDA;
        3'd7: dec_o.cls = C_SBC;
        default: dec_o.cls = C_NONE;
      endcase
      case (opcode_i[4:2])
        3'd0: dec_o.mode = M_XIND;
        3'd1: dec_o.mode = M_ZP;
        3'd2: dec_o.mode = M_IMM;
        3'd3: dec_o.mode = M_ABS;
        3'd4: dec_o.mode = M_INDY;
        3'd5: dec_o.mode = M_ZPX;
        3'd6: dec_o.mode = M_ABSY;
        default: dec_o.mode = M_ABSX;
      endcase
      if (dec_o.cls == C_NONE || (dec_o.cls == C_STA && dec_o.mode == M_IMM)) begin
        dec_o.cls  = C_NONE;
        dec_o.mode = M_NONE;
      end
    end else begin
      case (opcode_i)
        8'hA2: dec_o = '{C_LDX, M_IMM};
        8'hA6: dec_o = '{C_LDX, M_ZP};
        8'hB6: dec_o = '{C_LDX, M_ZPY};
        8'hAE: dec_o = '{C_LDX, M_ABS};
        8'hBE: dec_o = '{C_LDX, M_ABSY};
        8'hA0: dec_o = '{C_LDY, M_IMM};
        8'hA4: dec_o = '{C_LDY, M_ZP};
        8'hB4: dec_o = '{C_LDY, M_ZPX};
        8'hAC: dec_o = '{C_LDY, M_ABS};
        8'hBC: dec_o = '{C_LDY, M_ABSX};
        8'h86: dec_o = '{C_STX, M_ZP};
        8'h96: dec_o = '{C_STX, M_ZPY};
        8'h8E: dec_o = '{C_STX, M_ABS};
        8'h84: dec_o = '{C_STY, M_ZP};
        8'h94: dec_o = '{C_STY, M_ZPX};
        8'h8C: dec_o = '{C_STY, M_ABS};
        8'hC6: dec_o = '{C_DEC, M_ZP};
        8'hD6: dec_o = '{C_DEC, M_ZPX};
        8'hCE: dec_o = '{C_DEC, M_ABS};
        8'hDE: dec_o = '{C_DEC, M_ABSX};
        8'hE6: dec_o = '{C_INC, M_ZP};
        8'hF6: dec_o = '{C_INC, M_ZPX};
        8'hEE: dec_o = '{C_INC, M_ABS};
        8'hFE: dec_o = '{C_INC, M_ABSX};
        8'hAA: dec_o = '{C_TAX, M_IMP};
        8'hA8: dec_o = '{C_TAY, M_IMP};
        8'hBA: dec_o = '{C_TSX, M_IMP};
        8'h8A: dec_o = '{C_TXA, M_IMP};
        8'h9A: dec_o = '{C_TXS, M_IMP};
        8'h98: dec_o = '{C_TYA, M_IMP};
        8'hCA: dec_o = '{C_DEX, M_IMP};
        8'h88: dec_o = '{C_DEY, M_IMP};
        8'hE8: dec_o = '{C_INX, M_IMP};
        8'hC8: dec_o = '{C_INY, M_IMP};
        8'h48: dec_o = '{C_PHA, M_PUSH};
        8'h08: dec_o = '{C_PHP, M_PUSH};
        8'h68: dec_o = '{C_PLA, M_PULL};
        8'h28: dec_o = '{C_PLP, M_PULL};
        default: dec_o = '{C_NONE, M_NONE};
      endcase
    end
  end

endmodule

@@ rtl/eight_bit_cpu_core_subset.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_core_subset
// Cycle-by-cycle core: one read byte in, one bus cycle out.
// ----------------------------------------------------------------------------
// Each accepted request carries the byte answering the previous bus read and
// produces exactly one bus cycle result (read, write or internal) together
// with A, X, Y, SP and P after that cycle. One request is taken per clock:
// the whole cycle step is one pass of combinational logic from the
// architectural registers into the result register, and the next request is
// accepted while a result waits, as long as the result register is free or
// being drained in the same cycle. After reset the first three results read
// the reset vector and fetch the first opcode. Decimal mode is not modeled.
module eight_bit_cpu_core_subset import ebc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ebc_in_if.sink    in_i,
  ebc_out_if.source out_o
);

  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic [7:0]  op_q, op_d, ptr_q, ptr_d;
  logic [15:0] pc_q, pc_d, ea_q, ea_d;
  logic [3:0]  st_q, st_d;
  logic [1:0]  rp_q, rp_d;
  logic        ov_q;
  res_t        res_q, res_d;
  dec_t        dec;
  logic [7:0]  d, opc;
  logic        acc;

  assign in_i.ready = !ov_q || out_o.ready;
  assign acc = in_i.valid && in_i.ready;
  assign d = in_i.read_data;
  assign opc = (rp_q == RpRun && st_q == StOpc) ? d : op_q;

  ebc_decode u_dec (.opcode_i(opc), .dec_o(dec));

  // one bus cycle step
  always_comb begin
    logic [7:0]  idx, v, r;
    logic [8:0]  sum;
    logic        is_st, is_rmw, setnz;
    logic [7:0]  nzv;
    logic [15:0] baddr;
    logic [1:0]  kind;
    logic [7:0]  wd;
    logic        fetch;
    logic        do_oper;

    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    op_d = opc; ptr_d = ptr_q; pc_d = pc_q; ea_d = ea_q;
    st_d = st_q; rp_d = rp_q;
    baddr = '0; kind = KindRead; wd = '0; fetch = 1'b0;
    setnz = 1'b0; nzv = '0; do_oper = 1'b0;
    v = '0; r = '0; sum = '0;
    is_st  = dec.cls == C_STA || dec.cls == C_STX || dec.cls == C_STY;
    is_rmw = dec.cls == C_INC || dec.cls == C_DEC;
    idx = (dec.mode == M_ZPY || dec.mode == M_ABSY || dec.mode == M_INDY) ? y_q : x_q;

    case (rp_q)
      RpLow: begin
        baddr = VecLo; st_d = StVec; rp_d = RpHigh;
      end
      RpHigh: begin
        ptr_d = d; baddr = VecHi; st_d = StVec; rp_d = RpLoad;
      end
      RpLoad: begin
        baddr = {d, ptr_q}; fetch = 1'b1; pc_d = {d, ptr_q} + 16'd1;
        st_d = StOpc; rp_d = RpRun;
      end
      default: begin
        // default action is an opcode fetch
        baddr = pc_q; fetch = 1'b1; pc_d = pc_q + 16'd1; st_d = StOpc;
        case (st_q)
          StOpc: begin
            case (dec.mode)
              M_NONE: ;
              M_IMP: begin
                fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StDone;
                setnz = 1'b1;
                case (dec.cls)
                  C_TAX: begin x_d = a_q;  nzv = a_q; end
                  C_TAY: begin y_d = a_q;  nzv = a_q; end
                  C_TSX: begin x_d = sp_q; nzv = sp_q; end
                  C_TXA: begin a_d = x_q;  nzv = x_q; end
                  C_TXS: begin sp_d = x_q; setnz = 1'b0; end
                  C_TYA: begin a_d = y_q;  nzv = y_q; end
                  C_DEX: begin x_d = x_q - 8'd1; nzv = x_d; end
                  C_DEY: begin y_d = y_q - 8'd1; nzv = y_d; end
                  C_INX: begin x_d = x_q + 8'd1; nzv = x_d; end
                  C_INY: begin y_d = y_q + 8'd1; nzv = y_d; end
                  default: setnz = 1'b0;
                endcase
              end
              M_PUSH: begin
                fetch = 1'b0; pc_d = pc_q; kind = KindWrite;
                baddr = {8'h01, sp_q};
                wd = (dec.cls == C_PHA) ? a_q : (p_q | 8'h30);
                sp_d = sp_q - 8'd1; st_d = StPush;
              end
              M_PULL: begin
                fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA2;
              end
              M_IMM: begin fetch = 1'b0; st_d = StData; end
              default: begin fetch = 1'b0; st_d = StA2; end
            endcase
          end
          StData: begin
            setnz = 1'b1; nzv = d;
            case (dec.cls)
              C_LDA, C_PLA: a_d = d;
              C_LDX: x_d = d;
              C_LDY: y_d = d;
              C_ADC, C_SBC: begin
                v = (dec.cls == C_SBC) ? ~d : d;
                sum = {1'b0, a_q} + {1'b0, v} + {8'd0, p_q[0]};
                r = sum[7:0];
                a_d = r; nzv = r;
                p_d[0] = sum[8];
                p_d[6] = ((a_q ^ r) & (v ^ r) & 8'h80) != 8'h00;
              end
              C_AND: begin a_d = a_q & d; nzv = a_d; end
              C_EOR: begin a_d = a_q ^ d; nzv = a_d; end
              C_ORA: begin a_d = a_q | d; nzv = a_d; end
              C_PLP: begin setnz = 1'b0; p_d = (d & 8'hCF) | 8'h20; end
              default: setnz = 1'b0;
            endcase
          end
          StDone: ;
          StRmwR: begin
            fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StRmwW;
            ptr_d = (dec.cls == C_INC) ? d + 8'd1 : d - 8'd1;
            setnz = 1'b1; nzv = ptr_d;
          end
          StRmwW: begin
            fetch = 1'b0; pc_d = pc_q; kind = KindWrite; baddr = ea_q;
            wd = ptr_q; st_d = StDone;
          end
          StPush: begin
            fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StDone;
          end
          default: begin
            // addressing sequences
            case (dec.mode)
              M_ZP: if (st_q == StA2) begin ea_d = {8'd0, d}; do_oper = 1'b1; end
              M_ZPX, M_ZPY: begin
                if (st_q == StA2) begin
                  ea_d = {8'd0, d + idx};
                  fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA3;
                end else if (st_q == StA3) do_oper = 1'b1;
              end
              M_ABS, M_ABSX, M_ABSY: begin
                if (st_q == StA2) begin
                  ptr_d = d; fetch = 1'b0; st_d = StA3;
                end else if (st_q == StA3) begin
                  if (dec.mode == M_ABS) begin
                    ea_d = {d, ptr_q}; do_oper = 1'b1;
                  end else begin
                    sum = {1'b0, ptr_q} + {1'b0, idx};
                    ea_d = {d, 8'd0} + {7'd0, sum};
                    if (sum[8] || is_st || is_rmw) begin
                      fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA4;
                    end else do_oper = 1'b1;
                  end
                end else if (st_q == StA4 && dec.mode != M_ABS) do_oper = 1'b1;
              end
              M_XIND: begin
                if (st_q == StA2) begin
                  ptr_d = d + x_q;
                  fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA3;
                end else if (st_q == StA3) begin
                  fetch = 1'b0; pc_d = pc_q; baddr = {8'd0, ptr_q}; st_d = StA4;
                end else if (st_q == StA4) begin
                  ea_d = {8'd0, d}; fetch = 1'b0; pc_d = pc_q;
                  baddr = {8'd0, ptr_q + 8'd1}; st_d = StA5;
                end else if (st_q == StA5) begin
                  ea_d = {d, ea_q[7:0]}; do_oper = 1'b1;
                end
              end
              M_INDY: begin
                if (st_q == StA2) begin
                  ptr_d = d; fetch = 1'b0; pc_d = pc_q; baddr = {8'd0, d}; st_d = StA3;
                end else if (st_q == StA3) begin
                  ea_d = {8'd0, d}; fetch = 1'b0; pc_d = pc_q;
                  baddr = {8'd0, ptr_q + 8'd1}; st_d = StA4;
                end else if (st_q == StA4) begin
                  sum = {1'b0, ea_q[7:0]} + {1'b0, idx};
                  ea_d = {d, 8'd0} + {7'd0, sum};
                  if (sum[8] || is_st) begin
                    fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA5;
                  end else do_oper = 1'b1;
                end else if (st_q == StA5) do_oper = 1'b1;
              end
              M_PULL: begin
                if (st_q == StA2) begin
                  sp_d = sp_q + 8'd1;
                  fetch = 1'b0; baddr = '0; pc_d = pc_q; kind = KindIdle; st_d = StA3;
                end else if (st_q == StA3) begin
                  fetch = 1'b0; pc_d = pc_q; baddr = {8'h01, sp_q}; st_d = StData;
                end
              end
              default: ;
            endcase
          end
        endcase
        // operand access at the effective address
        if (do_oper) begin
          fetch = 1'b0; pc_d = pc_q; baddr = ea_d;
          if (is_st) begin
            kind = KindWrite; st_d = StDone;
            wd = (dec.cls == C_STA) ? a_q : ((dec.cls == C_STX) ? x_q : y_q);
          end else if (is_rmw) st_d = StRmwR;
          else st_d = StData;
        end
      end
    endcase

    if (setnz) begin
      p_d[7] = nzv[7];
      p_d[1] = nzv == 8'd0;
    end

    res_d.bus_address  = baddr;
    res_d.access_kind  = kind;
    res_d.write_data   = wd;
    res_d.opcode_fetch = fetch;
    res_d.acc_value    = a_d;
    res_d.x_value      = x_d;
    res_d.y_value      = y_d;
    res_d.stack_value  = sp_d;
    res_d.flag_bits    = p_d;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= SpRst; p_q <= PRst;
      op_q <= '0; ptr_q <= '0; pc_q <= '0; ea_q <= '0;
      st_q <= StVec; rp_q <= RpLow;
    end else if (acc) begin
      a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
      op_q <= op_d; ptr_q <= ptr_d; pc_q <= pc_d; ea_q <= ea_d;
      st_q <= st_d; rp_q <= rp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (acc) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.bus_address  = res_q.bus_address;
  assign out_o.access_kind  = res_q.access_kind;
  assign out_o.write_data   = res_q.write_data;
  assign out_o.opcode_fetch = res_q.opcode_fetch;
  assign out_o.acc_value    = res_q.acc_value;
  assign out_o.x_value      = res_q.x_value;
  assign out_o.y_value      = res_q.y_value;
  assign out_o.stack_value  = res_q.stack_value;
  assign out_o.flag_bits    = res_q.flag_bits;

endmodule

@@ tb/eight_bit_cpu_core_subset_tb.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_core_subset_tb
// Drives read bytes into the core, predicts every bus cycle it must produce
// and compares each result against the prediction, with random idling on
// both channels and opcode-aware stimulus so real instruction flows run.
// ----------------------------------------------------------------------------
module eight_bit_cpu_core_subset_tb import ebc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class cpu_cycle_scoreboard;

    // architectural and sequencing state of the predicted core
    logic [7:0]  a_q, x_q, y_q, sp_q, p_q, op_q, ptr_q;
    logic [3:0]  step_q;
    logic [15:0] pc_q, ea_q;
    logic [1:0]  vec_q;
    res_t        cyc;
    res_t        bus_cycles[$];
    bit          next_is_opcode;
    int          mismatches;

    function new();
      a_q = 0; x_q = 0; y_q = 0; sp_q = SpRst; p_q = PRst; op_q = 0; ptr_q = 0;
      step_q = StVec; pc_q = 0; ea_q = 0; vec_q = RpLow;
      next_is_opcode = 0; mismatches = 0;
    endfunction

    function automatic dec_t decode_op(logic [7:0] op);
      dec_t r;
      r.cls = C_NONE; r.mode = M_NONE;
      if (op[1:0] == 2'b01) begin
        case (op[7:5])
          3'd0: r.cls = C_ORA; 3'd1: r.cls = C_AND; 3'd2: r.cls = C_EOR;
          3'd3: r.cls = C_ADC; 3'd4: r.cls = C_STA; 3'd5: r.cls = C_LDA;
          3'd6: r.cls = C_NONE; default: r.cls = C_SBC;
        endcase
        case (op[4:2])
          3'd0: r.mode = M_XIND; 3'd1: r.mode = M_ZP; 3'd2: r.mode = M_IMM;
          3'd3: r.mode = M_ABS; 3'd4: r.mode = M_INDY; 3'd5: r.mode = M_ZPX;
          3'd6: r.mode = M_ABSY; default: r.mode = M_ABSX;
        endcase
        if (r.cls == C_NONE || (r.cls == C_STA && r.mode == M_IMM)) begin
          r.cls = C_NONE; r.mode = M_NONE;
        end
        return r;
      end
      case (op)
        8'hA2: r = '{C_LDX, M_IMM};  8'hA6: r = '{C_LDX, M_ZP};
        8'hB6: r = '{C_LDX, M_ZPY};  8'hAE: r = '{C_LDX, M_ABS};
        8'hBE: r = '{C_LDX, M_ABSY}; 8'hA0: r = '{C_LDY, M_IMM};
        8'hA4: r = '{C_LDY, M_ZP};   8'hB4: r = '{C_LDY, M_ZPX};
        8'hAC: r = '{C_LDY, M_ABS};  8'hBC: r = '{C_LDY, M_ABSX};
        8'h86: r = '{C_STX, M_ZP};   8'h96: r = '{C_STX, M_ZPY};
        8'h8E: r = '{C_STX, M_ABS};  8'h84: r = '{C_STY, M_ZP};
        8'h94: r = '{C_STY, M_ZPX};  8'h8C: r = '{C_STY, M_ABS};
        8'hC6: r = '{C_DEC, M_ZP};   8'hD6: r = '{C_DEC, M_ZPX};
        8'hCE: r = '{C_DEC, M_ABS};  8'hDE: r = '{C_DEC, M_ABSX};
        8'hE6: r = '{C_INC, M_ZP};   8'hF6: r = '{C_INC, M_ZPX};
        8'hEE: r = '{C_INC, M_ABS};  8'hFE: r = '{C_INC, M_ABSX};
        8'hAA: r = '{C_TAX, M_IMP};  8'hA8: r = '{C_TAY, M_IMP};
        8'hBA: r = '{C_TSX, M_IMP};  8'h8A: r = '{C_TXA, M_IMP};
        8'h9A: r = '{C_TXS, M_IMP};  8'h98: r = '{C_TYA, M_IMP};
        8'hCA: r = '{C_DEX, M_IMP};  8'h88: r = '{C_DEY, M_IMP};
        8'hE8: r = '{C_INX, M_IMP};  8'hC8: r = '{C_INY, M_IMP};
        8'h48: r = '{C_PHA, M_PUSH}; 8'h08: r = '{C_PHP, M_PUSH};
        8'h68: r = '{C_PLA, M_PULL}; 8'h28: r = '{C_PLP, M_PULL};
        default: ;
      endcase
      return r;
    endfunction

    function void drive_bus(logic [15:0] a, logic [1:0] k, logic [7:0] w, logic f);
      cyc.bus_address = a; cyc.access_kind = k; cyc.write_data = w;
      cyc.opcode_fetch = f;
    endfunction

    function void go_fetch();
      drive_bus(pc_q, KindRead, 8'h00, 1'b1);
      pc_q = pc_q + 16'd1;
      step_q = StOpc;
    endfunction

    function void read_cyc(logic [15:0] a, logic [3:0] nxt);
      drive_bus(a, KindRead, 8'h00, 1'b0);
      step_q = nxt;
    endfunction

    function void read_pc(logic [3:0] nxt);
      read_cyc(pc_q, nxt);
      pc_q = pc_q + 16'd1;
    endfunction

    function void idle_cyc(logic [3:0] nxt);
      drive_bus(16'h0000, KindIdle, 8'h00, 1'b0);
      step_q = nxt;
    endfunction

    function void set_nz(logic [7:0] v);
      p_q[7] = v[7];
      p_q[1] = (v == 8'h00);
    endfunction

    function void add_carry(logic [7:0] v);
      logic [8:0] sum;
      sum = {1'b0, a_q} + {1'b0, v} + {8'h00, p_q[0]};
      p_q[0] = sum[8];
      p_q[6] = (a_q[7] ^ sum[7]) & (v[7] ^ sum[7]);
      a_q = sum[7:0];
      set_nz(a_q);
    endfunction

    function bit is_store(cls_e c);
      return c == C_STA || c == C_STX || c == C_STY;
    endfunction

    function bit is_rmw(cls_e c);
      return c == C_INC || c == C_DEC;
    endfunction

    // operand access once the effective address is known
    function void operand_cyc(cls_e c);
      if (is_store(c)) begin
        drive_bus(ea_q, KindWrite, c == C_STA ? a_q : (c == C_STX ? x_q : y_q), 1'b0);
        step_q = StDone;
      end else if (is_rmw(c)) begin
        read_cyc(ea_q, StRmwR);
      end else begin
        read_cyc(ea_q, StData);
      end
    endfunction

    function void address_cyc(dec_t dc, logic [7:0] d);
      logic [7:0] idx;
      logic [8:0] sum;
      logic [3:0] t;
      bit         abs_any;
      t = step_q;
      idx = (dc.mode == M_ZPY || dc.mode == M_ABSY || dc.mode == M_INDY) ? y_q : x_q;
      abs_any = dc.mode == M_ABS || dc.mode == M_ABSX || dc.mode == M_ABSY;
      if (dc.mode == M_ZP && t == StA2) begin
        ea_q = {8'h00, d}; operand_cyc(dc.cls);
      end else if ((dc.mode == M_ZPX || dc.mode == M_ZPY) && t == StA2) begin
        ea_q = {8'h00, d + idx}; idle_cyc(StA3);
      end else if ((dc.mode == M_ZPX || dc.mode == M_ZPY) && t == StA3) begin
        operand_cyc(dc.cls);
      end else if (abs_any && t == StA2) begin
        ptr_q = d; read_pc(StA3);
      end else if (dc.mode == M_ABS && t == StA3) begin
        ea_q = {d, ptr_q}; operand_cyc(dc.cls);
      end else if ((dc.mode == M_ABSX || dc.mode == M_ABSY) && t == StA3) begin
        sum = {1'b0, ptr_q} + {1'b0, idx};
        ea_q = {d, 8'h00} + {7'h00, sum};
        if (sum[8] || is_store(dc.cls) || is_rmw(dc.cls)) idle_cyc(StA4);
        else operand_cyc(dc.cls);
      end else if ((dc.mode == M_ABSX || dc.mode == M_ABSY) && t == StA4) begin
        operand_cyc(dc.cls);
      end else if (dc.mode == M_XIND && t == StA2) begin
        ptr_q = d + x_q; idle_cyc(StA3);
      end else if (dc.mode == M_XIND && t == StA3) begin
        read_cyc({8'h00, ptr_q}, StA4);
      end else if ((dc.mode == M_XIND && t == StA4) || (dc.mode == M_INDY && t == StA3)) begin
        // high pointer byte wraps inside page zero
        ea_q = {8'h00, d};
        read_cyc({8'h00, ptr_q + 8'd1}, t + 4'd1);
      end else if (dc.mode == M_XIND && t == StA5) begin
        ea_q[15:8] = d; operand_cyc(dc.cls);
      end else if (dc.mode == M_INDY && t == StA2) begin
        ptr_q = d; read_cyc({8'h00, d}, StA3);
      end else if (dc.mode == M_INDY && t == StA4) begin
        sum = {1'b0, ea_q[7:0]} + {1'b0, idx};
        ea_q = {d, 8'h00} + {7'h00, sum};
        if (sum[8] || is_store(dc.cls)) idle_cyc(StA5);
        else operand_cyc(dc.cls);
      end else if (dc.mode == M_INDY && t == StA5) begin
        operand_cyc(dc.cls);
      end else if (dc.mode == M_PULL && t == StA2) begin
        sp_q = sp_q + 8'd1; idle_cyc(StA3);
      end else if (dc.mode == M_PULL && t == StA3) begin
        read_cyc({8'h01, sp_q}, StData);
      end else begin
        go_fetch();
      end
    endfunction

    function void execute_cyc(logic [7:0] d);
      dec_t dc;
      if (step_q == StOpc) op_q = d;
      dc = decode_op(op_q);
      case (step_q)
        StOpc: begin
          if (dc.mode == M_NONE) go_fetch();
          else if (dc.mode == M_IMP) begin
            case (dc.cls)
              C_TAX: begin x_q = a_q; set_nz(x_q); end
              C_TAY: begin y_q = a_q; set_nz(y_q); end
              C_TSX: begin x_q = sp_q; set_nz(x_q); end
              C_TXA: begin a_q = x_q; set_nz(a_q); end
              C_TXS: sp_q = x_q;
              C_TYA: begin a_q = y_q; set_nz(a_q); end
              C_DEX: begin x_q = x_q - 8'd1; set_nz(x_q); end
              C_DEY: begin y_q = y_q - 8'd1; set_nz(y_q); end
              C_INX: begin x_q = x_q + 8'd1; set_nz(x_q); end
              C_INY: begin y_q = y_q + 8'd1; set_nz(y_q); end
              default: ;
            endcase
            idle_cyc(StDone);
          end else if (dc.mode == M_PUSH) begin
            drive_bus({8'h01, sp_q}, KindWrite,
                      dc.cls == C_PHA ? a_q : (p_q | 8'h30), 1'b0);
            sp_q = sp_q - 8'd1;
            step_q = StPush;
          end else if (dc.mode == M_PULL) idle_cyc(StA2);
          else if (dc.mode == M_IMM) read_pc(StData);
          else read_pc(StA2);
        end
        StData: begin
          case (dc.cls)
            C_LDA, C_PLA: begin a_q = d; set_nz(d); end
            C_LDX: begin x_q = d; set_nz(d); end
            C_LDY: begin y_q = d; set_nz(d); end
            C_ADC: add_carry(d);
            C_SBC: add_carry(~d);
            C_AND: begin a_q = a_q & d; set_nz(a_q); end
            C_EOR: begin a_q = a_q ^ d; set_nz(a_q); end
            C_ORA: begin a_q = a_q | d; set_nz(a_q); end
            C_PLP: p_q = (d & 8'hCF) | 8'h20;
            default: ;
          endcase
          go_fetch();
        end
        StDone: go_fetch();
        StRmwR: begin
          ptr_q = (dc.cls == C_INC) ? d + 8'd1 : d - 8'd1;
          set_nz(ptr_q);
          idle_cyc(StRmwW);
        end
        StRmwW: begin
          drive_bus(ea_q, KindWrite, ptr_q, 1'b0);
          step_q = StDone;
        end
        StPush: idle_cyc(StDone);
        default: address_cyc(dc, d);
      endcase
    endfunction

    // one accepted request: predict the bus cycle it causes
    function void note_request(logic [7:0] d);
      case (vec_q)
        RpLow: begin read_cyc(VecLo, StVec); vec_q = RpHigh; end
        RpHigh: begin ptr_q = d; read_cyc(VecHi, StVec); vec_q = RpLoad; end
        RpLoad: begin pc_q = {d, ptr_q}; vec_q = RpRun; go_fetch(); end
        default: execute_cyc(d);
      endcase
      cyc.acc_value = a_q; cyc.x_value = x_q; cyc.y_value = y_q;
      cyc.stack_value = sp_q; cyc.flag_bits = p_q;
      next_is_opcode = cyc.opcode_fetch;
      bus_cycles.push_back(cyc);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (bus_cycles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected bus cycle %h", got);
        return;
      end
      want = bus_cycles.pop_front();
      if (got.bus_address != want.bus_address || got.access_kind != want.access_kind ||
          got.write_data != want.write_data || got.opcode_fetch != want.opcode_fetch ||
          got.acc_value != want.acc_value || got.x_value != want.x_value ||
          got.y_value != want.y_value || got.stack_value != want.stack_value ||
          got.flag_bits != want.flag_bits) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp addr %h kind %0d wd %h f %b a %h x %h y %h s %h p %h",
                   want.bus_address, want.access_kind, want.write_data,
                   want.opcode_fetch, want.acc_value, want.x_value, want.y_value,
                   want.stack_value, want.flag_bits);
          $display("          got addr %h kind %0d wd %h f %b a %h x %h y %h s %h p %h",
                   got.bus_address, got.access_kind, got.write_data,
                   got.opcode_fetch, got.acc_value, got.x_value, got.y_value,
                   got.stack_value, got.flag_bits);
        end
      end
    endfunction
  endclass

  localparam int NumRequests = 1350;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ebc_in_if  in_ch ();
  ebc_out_if out_ch ();

  eight_bit_cpu_core_subset dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cpu_cycle_scoreboard sb = new();
  logic [7:0] known_ops[$];
  int  idle_run = 0;
  bit  hold_req = 1'b0;
  bit  sent_all = 1'b0;

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.read_data = 8'h00;
    out_ch.ready = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pick the byte answering the previous cycle, opcode-aware
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (sb.next_is_opcode && r < 88)
      return known_ops[$urandom_range(0, known_ops.size() - 1)];
    if (r < 20) return 8'hFF;
    if (r < 30) return 8'h00;
    if (r < 36) return 8'h80;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_request(logic [7:0] d);
    in_ch.valid <= 1'b1;
    in_ch.read_data <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(d);
  endtask

  task automatic pause_after(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // request driver
  initial begin
    logic [7:0] directed_ops[$];
    logic [7:0] fill[4];
    int k, f;
    logic [7:0] d;
    directed_ops = '{8'hA9, 8'h69, 8'hE9, 8'hC9, 8'h89, 8'h08, 8'h28, 8'h91, 8'hFE};
    fill = '{8'hFF, 8'h80, 8'h7F, 8'h00};
    for (int op = 0; op < 256; op++)
      if (sb.decode_op(8'(op)).mode != M_NONE) known_ops.push_back(8'(op));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset vector 0x8000, then directed instructions with extreme operands
    send_request(8'h00);
    send_request(8'h00);
    send_request(8'h80);
    k = 0; f = 0;
    while (k < directed_ops.size()) begin
      if (sb.next_is_opcode) begin
        d = directed_ops[k]; k++;
      end else begin
        d = fill[f % 4]; f++;
      end
      send_request(d);
    end
    // random instruction flow
    for (int i = 0; i < NumRequests; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == 800) begin
        in_ch.valid <= 1'b0;
        wait (sb.bus_cycles.size() == 0);
        @(posedge clk_i);
      end
      send_request(pick_byte());
      if ((i / 150) % 3 != 1) pause_after(gap_len());
    end
    in_ch.valid <= 1'b0;
    sent_all = 1'b1;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int run_left;
    run_left = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (run_left > 0) begin
          run_left--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
          run_left = gap_len();
          out_ch.ready <= (run_left == 0);
        end else begin
          out_ch.ready <= 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  // result monitor and stall watchdog
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.bus_address, out_ch.access_kind, out_ch.write_data,
                        out_ch.opcode_fetch, out_ch.acc_value, out_ch.x_value,
                        out_ch.y_value, out_ch.stack_value, out_ch.flag_bits});
    end
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= StallLimit);
    $display("eight_bit_cpu_core_subset_tb: FAIL");
    $finish;
  end

  // end of run
  initial begin
    wait (sent_all);
    wait (sb.bus_cycles.size() == 0);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.bus_cycles.size() == 0) begin
      $display("eight_bit_cpu_core_subset_tb: PASS");
    end else begin
      $display("eight_bit_cpu_core_subset_tb: FAIL");
    end
    $finish;
  end

endmodule
